/* rtl/core/drfs_pkg.sv */
// ----------------------------------------------------------------------------
// drfs_pkg
// Shared types and constants for the delimited row field splitter.
// ----------------------------------------------------------------------------
package drfs_pkg;

  localparam int unsigned MAX_LINE = 4096;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned NUM_W    = 12;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [POS_W-1:0]  POS_MAX    = POS_W'(MAX_LINE);
  localparam logic [NUM_W-1:0]  NUM_MAX    = '1;
  localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'd34;
  localparam logic [BYTE_W-1:0] COMMA_BYTE = 8'd44;
  localparam logic [BYTE_W-1:0] DELIM_RST  = COMMA_BYTE;

  typedef enum logic [1:0] {
    MODE_PLAIN      = 2'd0,
    MODE_QUOTE      = 2'd1,
    MODE_AFTER_QUOTE = 2'd2
  } parse_mode_e;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] offset;
    logic [POS_W-1:0] length;
    logic [NUM_W-1:0] number;
    logic             present;
    logic             line_end;
    logic             overflow;
  } field_res_t;

endpackage

/* rtl/core/drfs_parser.sv */
// ----------------------------------------------------------------------------
// drfs_parser
// Line state and per-byte field decode; result is combinational on the
// current transaction, state advances when step_i is high.
// ----------------------------------------------------------------------------
module drfs_parser import drfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              cmd_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [BYTE_W-1:0] delim_i,
  output field_res_t        res_o
);

  parse_mode_e      mode_q, mode_d;
  logic [POS_W-1:0] start_q, start_d;
  logic [POS_W-1:0] line_q, line_d;
  logic             after_q, after_d;
  logic [NUM_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;

  logic             at_max;
  logic             ovf_next;
  logic [POS_W-1:0] len_w;
  logic [POS_W-1:0] nstart_w;
  logic             open_quote;
  logic             is_quote;

  assign at_max     = (line_q == POS_MAX);
  assign ovf_next   = ovf_q | at_max;
  assign len_w      = (line_q >= start_q) ? (line_q - start_q) : '0;
  assign nstart_w   = at_max ? POS_MAX : (line_q + POS_W'(1));
  assign is_quote   = (byte_i == QUOTE_BYTE);
  assign open_quote = (line_q == start_q) && is_quote;

  // next parse mode
  always_comb begin
    mode_d = mode_q;
    if (cmd_i) begin
      mode_d = MODE_PLAIN;
    end else begin
      unique case (mode_q)
        MODE_PLAIN:       if (open_quote) mode_d = MODE_QUOTE;
        MODE_QUOTE:       if (is_quote) mode_d = MODE_AFTER_QUOTE;
        MODE_AFTER_QUOTE: if (byte_i == COMMA_BYTE) mode_d = MODE_QUOTE;
        default:          mode_d = MODE_PLAIN;
      endcase
    end
  end

  // result and datapath state
  always_comb begin
    res_o   = '0;
    start_d = start_q;
    line_d  = line_q;
    after_d = after_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    if (cmd_i) begin
      res_o.valid    = 1'b1;
      res_o.line_end = 1'b1;
      res_o.overflow = ovf_q;
      if ((mode_q != MODE_AFTER_QUOTE) && ((len_w != '0) || after_q)) begin
        res_o.present = 1'b1;
        res_o.offset  = start_q;
        res_o.length  = len_w;
        res_o.number  = cnt_q;
      end
      start_d = '0;
      line_d  = '0;
      after_d = 1'b0;
      cnt_d   = '0;
      ovf_d   = 1'b0;
    end else begin
      ovf_d          = ovf_next;
      res_o.overflow = ovf_next;
      res_o.offset   = start_q;
      res_o.length   = len_w;
      res_o.number   = cnt_q;
      line_d         = at_max ? line_q : (line_q + POS_W'(1));
      unique case (mode_q)
        MODE_PLAIN: begin
          if (open_quote) begin
            start_d = nstart_w;
          end else begin
            after_d = 1'b0;
            if (byte_i == delim_i) begin
              res_o.valid   = 1'b1;
              res_o.present = 1'b1;
              start_d       = nstart_w;
              after_d       = 1'b1;
            end
          end
        end
        MODE_QUOTE: begin
          if (is_quote) begin
            res_o.valid   = 1'b1;
            res_o.present = 1'b1;
            after_d       = 1'b0;
          end
        end
        MODE_AFTER_QUOTE: begin
          if (byte_i == COMMA_BYTE) begin
            start_d = nstart_w;
            after_d = 1'b1;
          end
        end
        default: ;
      endcase
      if (res_o.valid && (cnt_q != NUM_MAX)) begin
        cnt_d = cnt_q + NUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PLAIN;
      start_q <= '0;
      line_q  <= '0;
      after_q <= 1'b0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      line_q  <= line_d;
      after_q <= after_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

/* rtl/core/delimited_row_field_splitter_core.sv */
// ----------------------------------------------------------------------------
// delimited_row_field_splitter_core
// Splits a byte stream of text lines into fields, one offset/length
// transaction per closed field and one per end of line, which also carries the last field if it is open.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  s_axis    in   tdata = text_byte, tuser = command (1 = end of line)
//  m_axis    out  tdata = offset, length, number; tuser = present, overflow;
//                 tlast = line_end
//  cfg       in   delimiter byte, written when cfg_we_i is high
//
//  One transaction accepted per cycle; the path runs through an input register,
//  then a result register. Bytes that close no field produce no output.
//  m_axis_tready low stalls the result register and, once the input
//  register is full, s_axis_tready. Reset clears line state and sets the
//  delimiter to comma.
// ----------------------------------------------------------------------------
module delimited_row_field_splitter_core import drfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] text_byte
  input  logic              s_axis_tuser,   // [0] command
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // [12:0] offset, [25:13] length,
                                            // [37:26] number, [39:38] zero
  output logic [1:0]        m_axis_tuser,   // [0] field_present, [1] overflow
  output logic              m_axis_tlast    // line_end
);

  logic [BYTE_W-1:0] delim_q;
  logic              in_vld_q;
  logic              in_cmd_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              out_vld_q;
  field_res_t        out_res_q;
  field_res_t        res_w;
  logic              out_free;
  logic              step;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  drfs_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .cmd_i   (in_cmd_q),
    .byte_i  (in_byte_q),
    .delim_i (delim_q),
    .res_o   (res_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RST;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && res_w.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_w.valid && out_free) begin
      out_res_q <= res_w;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_res_q.number, out_res_q.length, out_res_q.offset};
  assign m_axis_tuser  = {out_res_q.overflow, out_res_q.present};
  assign m_axis_tlast  = out_res_q.line_end;

endmodule

/* sim/drfs_field_checker.sv */
// ----------------------------------------------------------------------------
// drfs_field_checker
// Watches the byte, field and delimiter channels of the row field splitter,
// predicts every field report from the accepted byte stream and compares each
// field report transaction, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module drfs_field_checker import drfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [39:0]       m_axis_tdata,
  input  logic [1:0]        m_axis_tuser,
  input  logic              m_axis_tlast,
  output int unsigned       errors_o,
  output int unsigned       pending_o,
  output int unsigned       lines_o,
  output int unsigned       fields_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0] offset;
    logic [POS_W-1:0] length;
    logic [NUM_W-1:0] number;
    logic             present;
    logic             line_end;
    logic             overflow;
  } split_t;

  logic [BYTE_W-1:0] delim_q;
  parse_mode_e       mode_q;
  logic [POS_W-1:0]  start_q;
  logic [POS_W-1:0]  pos_q;
  logic              after_delim_q;
  logic [NUM_W-1:0]  count_q;
  logic              ovf_q;

  split_t      pending_fields[$];
  int unsigned mismatches;
  int unsigned lines_seen;
  int unsigned fields_seen;

  function automatic void clear_line();
    mode_q        = MODE_PLAIN;
    start_q       = '0;
    pos_q         = '0;
    after_delim_q = 1'b0;
    count_q       = '0;
    ovf_q         = 1'b0;
  endfunction

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    return (p >= POS_MAX) ? POS_MAX : p + POS_W'(1);
  endfunction

  function automatic split_t close_field(input logic [POS_W-1:0] end_pos);
    split_t r;
    r          = '0;
    r.offset   = start_q;
    r.length   = (end_pos >= start_q) ? end_pos - start_q : '0;
    r.number   = count_q;
    r.present  = 1'b1;
    r.overflow = ovf_q;
    if (count_q != NUM_MAX) count_q++;
    return r;
  endfunction

  // Advances the line state by one byte or end of line; returns 1 when a
  // field report is due.
  function automatic bit split_step(input logic cmd, input logic [7:0] ch,
                                    output split_t r);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] len;
    bit               hit;
    hit = 1'b0;
    r   = '0;
    if (cmd) begin
      len        = (pos_q >= start_q) ? pos_q - start_q : '0;
      r.line_end = 1'b1;
      r.overflow = ovf_q;
      if (mode_q != MODE_AFTER_QUOTE && (len != 0 || after_delim_q)) begin
        r.offset  = start_q;
        r.length  = len;
        r.number  = count_q;
        r.present = 1'b1;
      end
      clear_line();
      return 1'b1;
    end
    if (pos_q >= POS_MAX) begin
      ovf_q = 1'b1;
      p     = POS_MAX;
    end else begin
      p = pos_q;
    end
    case (mode_q)
      MODE_PLAIN: begin
        // opening quote wins over the delimiter
        if (p == start_q && ch == QUOTE_BYTE) begin
          mode_q  = MODE_QUOTE;
          start_q = next_pos(p);
        end else begin
          after_delim_q = 1'b0;
          if (ch == delim_q) begin
            r             = close_field(p);
            hit           = 1'b1;
            start_q       = next_pos(p);
            after_delim_q = 1'b1;
          end
        end
      end
      MODE_QUOTE: begin
        if (ch == QUOTE_BYTE) begin
          r             = close_field(p);
          hit           = 1'b1;
          mode_q        = MODE_AFTER_QUOTE;
          after_delim_q = 1'b0;
        end
      end
      default: begin
        if (ch == COMMA_BYTE) begin
          start_q       = next_pos(p);
          mode_q        = MODE_QUOTE;
          after_delim_q = 1'b1;
        end
      end
    endcase
    if (pos_q < POS_MAX) pos_q++;
    return hit;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    split_t want;
    split_t got;
    if (!rst_ni) begin
      delim_q = DELIM_RST;
      clear_line();
      pending_fields.delete();
      mismatches  = 0;
      lines_seen  = 0;
      fields_seen = 0;
      errors_o  <= 0;
      pending_o <= 0;
      lines_o   <= 0;
      fields_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.offset   = m_axis_tdata[POS_W-1:0];
        got.length   = m_axis_tdata[2*POS_W-1:POS_W];
        got.number   = m_axis_tdata[2*POS_W+NUM_W-1:2*POS_W];
        got.present  = m_axis_tuser[0];
        got.overflow = m_axis_tuser[1];
        got.line_end = m_axis_tlast;
        if (pending_fields.size() == 0) begin
          $error("field transaction with nothing expected: offset %0d length %0d",
                 got.offset, got.length);
          mismatches++;
        end else begin
          want = pending_fields.pop_front();
          compare_field("field_offset", 32'(want.offset), 32'(got.offset));
          compare_field("field_length", 32'(want.length), 32'(got.length));
          compare_field("field_number", 32'(want.number), 32'(got.number));
          compare_field("field_present", 32'(want.present), 32'(got.present));
          compare_field("line_end", 32'(want.line_end), 32'(got.line_end));
          compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
        end
        if (got.present) fields_seen++;
      end
      if (cfg_we_i) delim_q = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (split_step(s_axis_tuser, s_axis_tdata, want)) pending_fields.push_back(want);
        if (s_axis_tuser) lines_seen++;
      end
      errors_o  <= mismatches;
      pending_o <= pending_fields.size();
      lines_o   <= lines_seen;
      fields_o  <= fields_seen;
    end
  end

endmodule

/* sim/tb_delimited_row_field_splitter_core.sv */
// ----------------------------------------------------------------------------
// tb_delimited_row_field_splitter_core
// Drives text lines into the row field splitter under random source idles and
// sink stalls (none in the comma phase): directed quoting corner cases, then
// random rows under several delimiter settings. A side checker predicts and
// compares field reports.
module tb_delimited_row_field_splitter_core;
  import drfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [BYTE_W-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;

  int unsigned errors;
  int unsigned pending;
  int unsigned lines_done;
  int unsigned fields_done;
  int unsigned items_sent = 0;
  logic        calm = 1'b0;
  logic [7:0]  phase_delims[5];

  delimited_row_field_splitter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  drfs_field_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors_o      (errors),
    .pending_o     (pending),
    .lines_o       (lines_done),
    .fields_o      (fields_done)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 31);
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // source holds off until every field report is back, then lets the
  // pipeline empty out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_delim(input logic [7:0] d);
    cfg_wdata_i <= d;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // quoted and plain fields with random content
  task automatic send_row(input logic [7:0] delim);
    int         n_fields;
    int         n_chars;
    logic [7:0] b;
    n_fields = $urandom_range(1, 5);
    for (int f = 0; f < n_fields; f++) begin
      n_chars = $urandom_range(0, 6);
      if ($urandom_range(99) < 40) begin
        send_item(CMD_TEXT, QUOTE_BYTE);
        repeat (n_chars) begin
          b = 8'($urandom_range(255));
          if (b == QUOTE_BYTE) b = 8'h71;
          send_item(CMD_TEXT, b);
        end
        send_item(CMD_TEXT, QUOTE_BYTE);
        if (f < n_fields - 1) send_item(CMD_TEXT, COMMA_BYTE);
      end else begin
        repeat (n_chars) begin
          b = 8'($urandom_range(255));
          if (b == delim) b = b ^ 8'h01;
          send_item(CMD_TEXT, b);
        end
        if (f < n_fields - 1) send_item(CMD_TEXT, delim);
      end
    end
    send_item(CMD_EOL, 8'($urandom_range(255)));
  endtask

  task automatic send_noise(input logic [7:0] delim);
    int         n_chars;
    int         pick;
    logic [7:0] b;
    n_chars = $urandom_range(0, 24);
    repeat (n_chars) begin
      pick = $urandom_range(99);
      if (pick < 25)      b = delim;
      else if (pick < 40) b = QUOTE_BYTE;
      else if (pick < 50) b = COMMA_BYTE;
      else                b = 8'($urandom_range(255));
      send_item(CMD_TEXT, b);
    end
    send_item(CMD_EOL, 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned goal;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // quoted field, ignored byte after close, comma reopen, open quote at eol
    send_item(CMD_TEXT, QUOTE_BYTE);
    send_item(CMD_TEXT, 8'hFF);
    send_item(CMD_TEXT, QUOTE_BYTE);
    send_item(CMD_TEXT, 8'h78);
    send_item(CMD_TEXT, COMMA_BYTE);
    send_item(CMD_TEXT, 8'h00);
    send_item(CMD_EOL, 8'hFF);
    // empty field after a delimiter, then a bare end of line
    send_item(CMD_TEXT, COMMA_BYTE);
    send_item(CMD_EOL, 8'h00);
    send_item(CMD_EOL, 8'h00);
    // empty quoted field, eol right after the closing quote
    send_item(CMD_TEXT, QUOTE_BYTE);
    send_item(CMD_TEXT, QUOTE_BYTE);
    send_item(CMD_EOL, 8'h00);
    send_item(CMD_TEXT, 8'h61);
    send_item(CMD_TEXT, COMMA_BYTE);
    send_item(CMD_TEXT, 8'h62);
    send_item(CMD_EOL, 8'h00);
    drain();

    // delimiter equal to the quote byte
    write_delim(QUOTE_BYTE);
    send_item(CMD_TEXT, 8'h61);
    send_item(CMD_TEXT, QUOTE_BYTE);
    send_item(CMD_TEXT, QUOTE_BYTE);
    send_item(CMD_EOL, 8'h00);
    drain();

    phase_delims = '{8'h00, 8'hFF, COMMA_BYTE, QUOTE_BYTE, 8'($urandom_range(255))};
    foreach (phase_delims[p]) begin
      write_delim(phase_delims[p]);
      calm <= (p == 2);
      goal = items_sent + 200;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 70) send_row(phase_delims[p]);
        else                         send_noise(phase_delims[p]);
      end
      drain();
    end
    calm <= 1'b0;
    drain();

    $display("Covered %0d lines and %0d field reports from %0d input transactions,",
             lines_done, fields_done, items_sent);
    $display("delimiters 0, 255, comma, quote and random, with quoting corner cases.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
